>>> sv/revocation_tree_node_manager_assert.svh
// Assertion macros used by the checker file.
`ifndef REVOCATION_TREE_NODE_MANAGER_ASSERT_SVH
`define REVOCATION_TREE_NODE_MANAGER_ASSERT_SVH
// Implication checked every clock, muted during reset.
`define RTNM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication, muted during reset.
`define RTNM_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

>>> sv/rtnm_pkg.sv
// ---------------------------------------------------------------------------
// rtnm_pkg
// Shared types and constants for the revocation tree node manager.
// ---------------------------------------------------------------------------
`default_nettype none
package rtnm_pkg;
   localparam int NODE_COUNT = 1024;
   localparam int ID_BITS    = 10;
   localparam int LINK_BITS  = 11;
   localparam int DEPTH_BITS = 16;
   localparam int COUNT_BITS = 32;
   localparam logic [LINK_BITS-1:0] NONE_ID = 11'd1024;
   // entry: next, prev, depth, count, live
   localparam int ENTRY_BITS = 2*LINK_BITS + DEPTH_BITS + COUNT_BITS + 1;

   typedef enum logic [1:0] {
      CMD_QUERY  = 2'd0,
      CMD_ALLOC  = 2'd1,
      CMD_REVOKE = 2'd2,
      CMD_UPDATE = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NO_FREE  = 2'd1,
      ST_ZERO_DLT = 2'd2
   } status_type;

   typedef struct packed {
      logic [LINK_BITS-1:0]  next;
      logic [LINK_BITS-1:0]  prev;
      logic [DEPTH_BITS-1:0] depth;
      logic [COUNT_BITS-1:0] count;
      logic                  live;
   } entry_type;

   typedef struct packed {
      logic [1:0]          command;
      logic [ID_BITS-1:0]  node_id;
      logic                has_parent;
      logic signed [15:0]  delta;
   } req_type;

   typedef struct packed {
      logic [1:0]            status;
      logic [ID_BITS-1:0]    new_node;
      logic                  node_live;
      logic [DEPTH_BITS-1:0] node_depth;
      logic [COUNT_BITS-1:0] node_count;
      logic [LINK_BITS-1:0]  node_prev;
      logic [LINK_BITS-1:0]  node_next;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE, S_RD0, S_EXEC, S_A_NXT, S_A_TAKE, S_A_WR,
      S_V_RD, S_V_STEP, S_V_FIX, S_DONE
   } state_type;
endpackage
`default_nettype wire

>>> sv/rtnm_if.sv
// ---------------------------------------------------------------------------
// rtnm_req_if / rtnm_rsp_if
// Valid/ready item channels for requests and responses.
// ---------------------------------------------------------------------------
`default_nettype none
interface rtnm_req_if;
   import rtnm_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface rtnm_rsp_if;
   import rtnm_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> sv/rtnm_ram.sv
// ---------------------------------------------------------------------------
// rtnm_ram
// Generic single-port RAM with registered read.
// ---------------------------------------------------------------------------
`default_nettype none
module rtnm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule
`default_nettype wire

>>> sv/revocation_tree_node_manager.sv
// States, accept to response valid: query and update S_RD0, S_EXEC, S_DONE;
//   allocate adds S_A_NXT, S_A_TAKE, S_A_WR unless no node is free; revoke
//   adds S_V_RD, S_V_STEP per node read in the walk, then S_V_FIX.
// One item at a time: a new item waits until the last response is accepted.
// Reset: synchronous, active high; clears control, free-list head, fresh count
//   and list head. Node table has no reset; entries are defined once written.
// ---------------------------------------------------------------------------
// revocation_tree_node_manager
// Pre-order revocation tree with free list, held in one node-table RAM.
// ---------------------------------------------------------------------------
`default_nettype none
module revocation_tree_node_manager (
   input wire logic    clock,
   input wire logic    reset,
   rtnm_req_if.sink    req,
   rtnm_rsp_if.source  rsp
);
   import rtnm_pkg::*;

   state_type state_ff, state_in;
   req_type   cmd_ff, cmd_in;
   entry_type ent_ff, ent_in;       // target / parent entry
   logic [LINK_BITS-1:0] free_ff, free_in, fresh_ff, fresh_in, head_ff, head_in;
   logic [LINK_BITS-1:0] take_ff, take_in, nxt_ff, nxt_in, cur_ff, cur_in;
   logic [LINK_BITS-1:0] bef_ff, bef_in;
   logic [LINK_BITS-1:0] steps_ff, steps_in;
   logic                 fromfree_ff, fromfree_in, par_ff, par_in;
   rsp_type              out_ff, out_in;
   logic                 ovalid_ff, ovalid_in;

   logic                 we;
   logic [ID_BITS-1:0]   addr;
   entry_type            wdata, rdata;

   rtnm_ram #(.WIDTH(ENTRY_BITS), .DEPTH(NODE_COUNT)) u_ram (
      .clock(clock), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
   );

   function automatic logic [LINK_BITS-1:0] norm(input logic [LINK_BITS-1:0] id);
      return id[LINK_BITS-1] ? NONE_ID : id;
   endfunction

   // out_ff is rebuilt during execution, so hold off new items while a
   // response item still waits
   assign req.ready = (state_ff == S_IDLE) && !ovalid_ff;
   assign rsp.valid = ovalid_ff;
   assign rsp.data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         free_ff   <= NONE_ID;
         fresh_ff  <= '0;
         head_ff   <= NONE_ID;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         free_ff   <= free_in;
         fresh_ff  <= fresh_in;
         head_ff   <= head_in;
         ovalid_ff <= ovalid_in;
      end
      cmd_ff <= cmd_in; ent_ff <= ent_in; take_ff <= take_in; nxt_ff <= nxt_in;
      cur_ff <= cur_in; bef_ff <= bef_in; steps_ff <= steps_in;
      fromfree_ff <= fromfree_in; par_ff <= par_in; out_ff <= out_in;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (req.valid && req.ready) state_in = S_RD0;
         S_RD0:   state_in = S_EXEC;
         S_EXEC: begin
            unique case (cmd_type'(cmd_ff.command))
               CMD_QUERY, CMD_UPDATE: state_in = S_DONE;
               CMD_ALLOC: begin
                  if (free_ff == NONE_ID && fresh_ff == NONE_ID) state_in = S_DONE;
                  else state_in = S_A_NXT;
               end
               default: state_in = S_V_RD;
            endcase
         end
         S_A_NXT:  state_in = S_A_TAKE;
         S_A_TAKE: state_in = S_A_WR;
         S_A_WR:   state_in = S_DONE;
         S_V_RD:   state_in = S_V_STEP;
         S_V_STEP: begin
            if (cur_ff == NONE_ID || steps_ff == NONE_ID) state_in = S_V_FIX;
            else if (rdata.depth > ent_ff.depth) state_in = S_V_RD;
            else state_in = S_V_FIX;
         end
         S_V_FIX:  state_in = S_DONE;
         S_DONE:   if (!ovalid_ff || rsp.ready) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // datapath / outputs
   always_comb begin
      entry_type e;
      cmd_in = cmd_ff; ent_in = ent_ff; take_in = take_ff; nxt_in = nxt_ff;
      cur_in = cur_ff; bef_in = bef_ff; steps_in = steps_ff;
      fromfree_in = fromfree_ff; par_in = par_ff; out_in = out_ff;
      free_in = free_ff; fresh_in = fresh_ff; head_in = head_ff;
      ovalid_in = ovalid_ff && !rsp.ready;
      we = 1'b0; addr = cmd_ff.node_id; wdata = rdata; e = rdata;
      unique case (state_ff)
         S_IDLE: begin
            cmd_in = req.data;
            addr   = req.data.node_id;
         end
         S_RD0: addr = cmd_ff.node_id;
         S_EXEC: begin
            ent_in = rdata;
            out_in = '0;
            unique case (cmd_type'(cmd_ff.command))
               CMD_QUERY: begin
                  out_in.node_live  = rdata.live;
                  out_in.node_depth = rdata.depth;
                  out_in.node_count = rdata.count;
                  out_in.node_prev  = rdata.prev;
                  out_in.node_next  = rdata.next;
               end
               CMD_UPDATE: begin
                  if (cmd_ff.delta == '0) begin
                     out_in.status = ST_ZERO_DLT;
                  end else begin
                     e.count = rdata.count + COUNT_BITS'(cmd_ff.delta);
                     if (e.count == '0 && !rdata.live) begin
                        e.next  = norm(free_ff);
                        free_in = {1'b0, cmd_ff.node_id};
                     end
                     we = 1'b1; wdata = e;
                  end
               end
               CMD_ALLOC: begin
                  par_in = cmd_ff.has_parent;
                  if (free_ff != NONE_ID) begin
                     take_in = free_ff; fromfree_in = 1'b1;
                  end else begin
                     take_in = fresh_ff; fromfree_in = 1'b0;
                     if (fresh_ff == NONE_ID) out_in.status = ST_NO_FREE;
                  end
                  if (cmd_ff.has_parent) nxt_in = norm(rdata.next);
                  else nxt_in = norm(head_ff);
                  if (free_ff != NONE_ID || fresh_ff != NONE_ID) begin
                     out_in.new_node = (free_ff != NONE_ID) ?
                        free_ff[ID_BITS-1:0] : fresh_ff[ID_BITS-1:0];
                     if (cmd_ff.has_parent) begin
                        e.next = (free_ff != NONE_ID) ? free_ff : fresh_ff;
                        we = 1'b1; wdata = e;
                     end
                  end
               end
               default: begin
                  // revoke: clear root, maybe free, start walk
                  e.live = 1'b0;
                  cur_in = norm(rdata.next);
                  bef_in = norm(rdata.prev);
                  if (rdata.count == '0) begin
                     e.next = norm(free_ff);
                     free_in = {1'b0, cmd_ff.node_id};
                  end
                  we = 1'b1; wdata = e;
                  steps_in = '0;
               end
            endcase
         end
         S_A_NXT: begin
            // read old next to fix its prev
            addr = nxt_ff[ID_BITS-1:0];
         end
         S_A_TAKE: begin
            addr = nxt_ff[ID_BITS-1:0];
            e = rdata; e.prev = take_ff;
            if (nxt_ff != NONE_ID) begin
               we = 1'b1; wdata = e;
            end
         end
         S_A_WR: begin
            // read the taken entry; its next link is the new free-list head
            addr = take_ff[ID_BITS-1:0];
         end
         S_V_RD: addr = cur_ff[ID_BITS-1:0];
         S_V_STEP: begin
            addr = cur_ff[ID_BITS-1:0];
            if (cur_ff != NONE_ID && steps_ff != NONE_ID) begin
               e = rdata;
               if (rdata.depth > ent_ff.depth) begin
                  e.live = 1'b0;
                  cur_in = norm(rdata.next);
                  steps_in = steps_ff + 1'b1;
                  if (rdata.count == '0) begin
                     e.next = norm(free_ff);
                     free_in = cur_ff;
                  end
               end else begin
                  e.prev = bef_ff;
               end
               we = 1'b1; wdata = e;
            end
         end
         S_V_FIX: begin
            addr = bef_ff[ID_BITS-1:0];
            if (bef_ff == NONE_ID) head_in = cur_ff;
         end
         S_DONE: begin
            if (cmd_ff.command == CMD_ALLOC && out_ff.status == ST_OK) begin
               addr = take_ff[ID_BITS-1:0];
               if (!ovalid_ff || rsp.ready) begin
                  e.next  = nxt_ff;
                  e.prev  = par_ff ? {1'b0, cmd_ff.node_id} : NONE_ID;
                  e.depth = par_ff ? ent_ff.depth + 1'b1 : DEPTH_BITS'(1);
                  e.count = COUNT_BITS'(1);
                  e.live  = 1'b1;
                  we = 1'b1; wdata = e;
                  if (!par_ff) head_in = take_ff;
                  if (fromfree_ff) free_in = norm(rdata.next);
                  else fresh_in = fresh_ff + 1'b1;
               end
            end
            if (cmd_ff.command == CMD_REVOKE && bef_ff != NONE_ID) begin
               addr = bef_ff[ID_BITS-1:0];
               if (!ovalid_ff || rsp.ready) begin
                  e = rdata; e.next = cur_ff; we = 1'b1; wdata = e;
               end
            end
            if (!ovalid_ff || rsp.ready) ovalid_in = 1'b1;
         end
         default: ;
      endcase
   end
endmodule
`default_nettype wire

>>> sv/rtnm_checker.sv
// ---------------------------------------------------------------------------
// rtnm_checker
// Port-level checks on the node manager, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
`include "revocation_tree_node_manager_assert.svh"
module rtnm_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic [1:0] rsp_status
);
   `RTNM_ASSERT_NXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   `RTNM_ASSERT_IMP(a_status_code, clock, reset, rsp_valid, rsp_status != 2'd3)
   `RTNM_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
endmodule

bind revocation_tree_node_manager rtnm_checker u_rtnm_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_status(rsp.data.status)
);
`default_nettype wire

>>> test/revocation_tree_node_manager_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// revocation_tree_node_manager_checker
// Watches the request and response channels, keeps its own copy of the node
// table, works out the expected response of each accepted request and
// compares every accepted response field by field with the oldest one.
// ---------------------------------------------------------------------------
module revocation_tree_node_manager_checker (
   input  logic clock,
   input  logic reset,
   rtnm_req_if  req,
   rtnm_rsp_if  rsp,
   output int   failures,
   output int   nodes_issued,
   output int   results_pending
);
   import rtnm_pkg::*;

   logic [LINK_BITS-1:0]  next_tab [NODE_COUNT];
   logic [LINK_BITS-1:0]  prev_tab [NODE_COUNT];
   logic [DEPTH_BITS-1:0] depth_tab[NODE_COUNT];
   logic [COUNT_BITS-1:0] count_tab[NODE_COUNT];
   logic                  live_tab [NODE_COUNT];
   int free_top;
   int list_head;
   rsp_type expected_rsps[$];

   function automatic int norm(int v);
      return (v < NODE_COUNT) ? v : NODE_COUNT;
   endfunction

   function automatic void push_free(int id);
      next_tab[id] = LINK_BITS'(norm(free_top));
      free_top = id;
   endfunction

   function automatic void walk_revoke(int id);
      logic [DEPTH_BITS-1:0] root_depth;
      int cur, bef, aft, steps;
      root_depth = depth_tab[id];
      cur = norm(next_tab[id]);
      bef = norm(prev_tab[id]);
      live_tab[id] = 1'b0;
      if (count_tab[id] == '0) push_free(id);
      for (steps = 0; steps < NODE_COUNT && cur < NODE_COUNT; steps++) begin
         if (depth_tab[cur] > root_depth) begin
            aft = norm(next_tab[cur]);
            live_tab[cur] = 1'b0;
            if (count_tab[cur] == '0) push_free(cur);
            cur = aft;
         end else begin
            prev_tab[cur] = LINK_BITS'(bef);
            break;
         end
      end
      if (bef >= NODE_COUNT) list_head = cur;
      else next_tab[bef] = LINK_BITS'(cur);
   endfunction

   function automatic rsp_type apply_request(req_type r);
      rsp_type o;
      int take, nxt, next_free, parent;
      logic from_free, with_parent;
      logic [DEPTH_BITS-1:0] pdepth;
      o = '0;
      parent = r.node_id;
      case (cmd_type'(r.command))
         CMD_QUERY: begin
            o.node_live  = live_tab[parent];
            o.node_depth = depth_tab[parent];
            o.node_count = count_tab[parent];
            o.node_prev  = prev_tab[parent];
            o.node_next  = next_tab[parent];
         end
         CMD_ALLOC: begin
            next_free = NODE_COUNT;
            if (free_top < NODE_COUNT) begin
               take = free_top;
               from_free = 1'b1;
            end else if (nodes_issued < NODE_COUNT) begin
               take = nodes_issued;
               from_free = 1'b0;
            end else begin
               o.status = ST_NO_FREE;
               return o;
            end
            with_parent = r.has_parent;
            if (with_parent) begin
               nxt = norm(next_tab[parent]);
               pdepth = depth_tab[parent];
               next_tab[parent] = LINK_BITS'(take);
            end else begin
               nxt = norm(list_head);
               pdepth = '0;
            end
            if (nxt < NODE_COUNT) prev_tab[nxt] = LINK_BITS'(take);
            if (from_free) next_free = norm(next_tab[take]);
            prev_tab[take]  = with_parent ? LINK_BITS'(parent) : NONE_ID;
            next_tab[take]  = LINK_BITS'(nxt);
            depth_tab[take] = pdepth + 1'b1;
            count_tab[take] = 1;
            live_tab[take]  = 1'b1;
            if (!with_parent) list_head = take;
            if (from_free) free_top = next_free;
            else nodes_issued++;
            o.new_node = ID_BITS'(take);
         end
         CMD_REVOKE: walk_revoke(parent);
         default: begin
            if (r.delta == 0) begin
               o.status = ST_ZERO_DLT;
            end else begin
               count_tab[parent] = count_tab[parent] + COUNT_BITS'(signed'(r.delta));
               if (count_tab[parent] == '0 && !live_tab[parent]) push_free(parent);
            end
         end
      endcase
      return o;
   endfunction

   task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
         failures++;
      end
   endtask

   initial begin
      failures = 0;
      nodes_issued = 0;
      results_pending = 0;
      free_top = NODE_COUNT;
      list_head = NODE_COUNT;
   end

   always @(posedge clock) begin
      rsp_type e;
      if (!reset) begin
         if (req.valid && req.ready) expected_rsps.push_back(apply_request(req.data));
         if (rsp.valid && rsp.ready) begin
            if (expected_rsps.size() == 0) begin
               $error("response item with no request outstanding");
               failures++;
            end else begin
               e = expected_rsps.pop_front();
               check_field("status", e.status, rsp.data.status);
               check_field("new_node", e.new_node, rsp.data.new_node);
               check_field("node_live", e.node_live, rsp.data.node_live);
               check_field("node_depth", e.node_depth, rsp.data.node_depth);
               check_field("node_count", e.node_count, rsp.data.node_count);
               check_field("node_prev", e.node_prev, rsp.data.node_prev);
               check_field("node_next", e.node_next, rsp.data.node_next);
            end
         end
         results_pending = expected_rsps.size();
      end
   end
endmodule

>>> test/revocation_tree_node_manager_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// revocation_tree_node_manager_test
// Drives directed and random commands into the node manager with random
// gaps and back-pressure; the checker predicts and compares every response.
// ---------------------------------------------------------------------------
module revocation_tree_node_manager_test;
   import rtnm_pkg::*;

   logic clock;
   logic reset;
   int   failures, nodes_issued, results_pending;
   int   send_idle, recv_idle;   // percent of cycles each side idles
   int   hold_request;           // long receiver hold, in cycles
   int   i;

   rtnm_req_if req ();
   rtnm_rsp_if rsp ();

   revocation_tree_node_manager u_top (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source)
   );

   revocation_tree_node_manager_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req             (req),
      .rsp             (rsp),
      .failures        (failures),
      .nodes_issued    (nodes_issued),
      .results_pending (results_pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard stop in case the block hangs.
   initial begin
      #500ms;
      $display("Test completed with failures");
      $finish;
   end

   // Receiver: random ready, or a long hold when asked for one.
   initial begin
      int held;
      held = 0;
      rsp.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            held = hold_request;
            hold_request = 0;
         end
         if (held > 0) begin
            held--;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= ($urandom_range(99) >= recv_idle);
         end
      end
   end

   // Offer one item and wait for it to be taken; starts and ends at a falling edge.
   task automatic send_item(cmd_type cmd, int id, logic has_par, logic signed [15:0] dlt);
      req_type r;
      while ($urandom_range(99) < send_idle) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      r.command    = cmd;
      r.node_id    = ID_BITS'(id);
      r.has_parent = has_par;
      r.delta      = dlt;
      req.valid <= 1'b1;
      req.data  <= r;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Only nodes already handed out are ever named as a target or a parent,
   // so no never-written table entry is read.
   function automatic int known_node();
      return $urandom_range(nodes_issued - 1);
   endfunction

   function automatic logic signed [15:0] random_delta();
      case ($urandom_range(9))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return 16'(signed'($urandom));
         3: return 16'sd0;
         4, 5, 6: return -16'sd1;
         default: return 16'sd1;
      endcase
   endfunction

   task automatic send_random();
      int pick;
      pick = $urandom_range(99);
      if (nodes_issued == 0 || pick < 40) begin
         if (nodes_issued == 0 || $urandom_range(3) == 0)
            send_item(CMD_ALLOC, $urandom_range(NODE_COUNT - 1), 1'b0, 16'(signed'($urandom)));
         else
            send_item(CMD_ALLOC, known_node(), 1'b1, 16'(signed'($urandom)));
      end else if (pick < 60) begin
         send_item(CMD_QUERY, known_node(), 1'($urandom), 16'(signed'($urandom)));
      end else if (pick < 72) begin
         send_item(CMD_REVOKE, known_node(), 1'($urandom), 16'(signed'($urandom)));
      end else begin
         send_item(CMD_UPDATE, known_node(), 1'($urandom), random_delta());
      end
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      @(negedge clock);
      while (results_pending != 0) @(negedge clock);
   endtask

   initial begin
      reset = 1'b1;
      req.valid = 1'b0;
      req.data = '0;
      send_idle = 0;
      recv_idle = 0;
      hold_request = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: a root with a two-level chain under it.
      send_idle = 19;
      recv_idle = 87;
      send_item(CMD_ALLOC, 1023, 1'b0, 16'sd0);       // root, node 0
      send_item(CMD_ALLOC, 0, 1'b1, 16'sd0);          // child of 0
      send_item(CMD_ALLOC, 1, 1'b1, 16'sd0);          // grandchild
      send_item(CMD_QUERY, 0, 1'b0, 16'sd0);
      send_item(CMD_QUERY, 1, 1'b0, 16'sd0);
      send_item(CMD_QUERY, 2, 1'b0, 16'sd0);
      send_item(CMD_UPDATE, 0, 1'b0, 16'sd0);         // zero delta rejected
      send_item(CMD_UPDATE, 1, 1'b1, 16'sh7FFF);
      send_item(CMD_UPDATE, 1, 1'b0, 16'sh8000);      // back to zero, still live
      send_item(CMD_UPDATE, 2, 1'b0, -16'sd1);
      send_item(CMD_ALLOC, 0, 1'b0, 16'sd0);          // second root
      send_item(CMD_REVOKE, 0, 1'b0, 16'sd0);         // subtree walk, frees 1 and 2
      send_item(CMD_QUERY, 0, 1'b0, 16'sd0);
      send_item(CMD_QUERY, 3, 1'b0, 16'sd0);
      send_item(CMD_UPDATE, 0, 1'b0, -16'sd1);        // dead node reaches zero, freed
      send_item(CMD_ALLOC, 3, 1'b1, 16'sd0);          // reuse from the free list
      send_item(CMD_ALLOC, 3, 1'b1, 16'sd0);
      send_item(CMD_ALLOC, 3, 1'b1, 16'sd0);
      send_item(CMD_REVOKE, 3, 1'b0, 16'sd0);         // revoke a node with three children under it
      send_item(CMD_REVOKE, 3, 1'b0, 16'sd0);         // revoke it again
      send_item(CMD_UPDATE, 3, 1'b0, 16'sh8000);
      send_item(CMD_QUERY, 3, 1'b0, 16'sd0);
      drain();

      // Random, sender mostly busy and receiver mostly stalled.
      for (i = 0; i < 100; i++) send_random();
      drain();

      send_idle = 87;
      recv_idle = 19;
      for (i = 0; i < 100; i++) send_random();
      drain();

      // No idling; a long receiver hold backs the block up.
      send_idle = 0;
      recv_idle = 0;
      hold_request = 300;
      for (i = 0; i < 40; i++) send_random();
      drain();
      for (i = 0; i < 60; i++) send_random();
      drain();

      // Use up every fresh index, then hit the full table.
      while (nodes_issued < NODE_COUNT) begin
         if (nodes_issued > 0 && $urandom_range(1))
            send_item(CMD_ALLOC, known_node(), 1'b1, 16'sd0);
         else
            send_item(CMD_ALLOC, $urandom_range(NODE_COUNT - 1), 1'b0, 16'sd0);
      end
      for (i = 0; i < 8; i++) send_item(CMD_ALLOC, known_node(), 1'($urandom), 16'sd0);
      for (i = 0; i < 30; i++) send_random();

      // Let the last response come out and the block settle.
      drain();
      repeat (50) @(posedge clock);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
